/* design/sed_pkg.sv */
// Package for the string escape decoder: decoder modes, result kinds,
// the result record and the character helpers.
// No dependencies.
package sed_pkg;

  localparam int unsigned QDEPTH = 4;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX    = 2'd2,
    MODE_OCT    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_UNTERM = 2'd2
  } kind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [1:0] HEX_DIGITS = 2'd2;
  localparam logic [1:0] OCT_DIGITS = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  // Outcome of one byte in normal mode.
  typedef struct packed {
    logic    emit;
    result_t res;
    mode_t   mode;
  } norm_t;

  function automatic norm_t normal_step(input logic [7:0] b);
    norm_t n;
    n.emit     = 1'b1;
    n.mode     = MODE_NORMAL;
    n.res.data = b;
    n.res.kind = KIND_BYTE;
    n.res.last = 1'b0;
    case (b)
      CH_QUOTE: begin
        n.res.data = 8'h00;
        n.res.kind = KIND_CLOSED;
      end
      CH_NUL: begin
        n.res.kind = KIND_UNTERM;
      end
      CH_BSLASH: begin
        n.emit = 1'b0;
        n.mode = MODE_ESC;
      end
      default: ;
    endcase
    return n;
  endfunction

  // Control code for a simple escape letter; any other byte maps to itself.
  function automatic logic [7:0] esc_code(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      8'h61:   c = 8'd7;   // a
      8'h62:   c = 8'd8;   // b
      8'h66:   c = 8'd12;  // f
      8'h6E:   c = 8'd10;  // n
      8'h72:   c = 8'd13;  // r
      8'h74:   c = 8'd9;   // t
      8'h76:   c = 8'd11;  // v
      default: c = b;
    endcase
    return c;
  endfunction

  // Digit value in hex or octal; bit 4 flags a valid digit.
  function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
    logic [4:0] d;
    d = 5'd0;
    if (!hex) begin
      if (b inside {[8'h30:8'h37]}) d = {2'b10, b[2:0]};
    end else begin
      if (b inside {[8'h30:8'h39]}) d = {1'b1, b[3:0]};
      else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) d = {1'b1, b[3:0] + 4'd9};
    end
    return d;
  endfunction

endpackage

/* design/string_escape_decoder.sv */
// Top level of the string escape decoder: escape state machine and a
// small result queue feeding the output stream.
// Depends on sed_pkg.
//
// Decodes a C string literal body, one raw byte per input transaction, and
// emits decoded bytes plus an end marker (closed by quote or ended by a zero
// byte). One input byte is taken per cycle while s_tready is high; each gives zero, one or two
// results, and results leave at one per cycle while m_tready is high, so bytes that end a numeric
// escape early (two results) set the pace. A four-entry result queue sits
// between the sides; input is taken while at most two entries are occupied.
// Escape state updates in the cycle the byte is taken, with no loop across
// cycles.
module string_escape_decoder
  import sed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [1:0] kind
  output logic       m_tlast    // last_of_run
);

  mode_t      mode, mode_next;
  logic [1:0] digits_left, digits_left_next;
  logic [7:0] accum, accum_next;

  result_t    q [QDEPTH];
  result_t    q_next [QDEPTH];
  logic [2:0] count, count_next;

  logic       accept, pop;
  logic [1:0] n_res;
  result_t    r0, r1;

  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (count <= 3'd2);
  assign m_tvalid = (count != 3'd0);
  assign m_tdata  = q[0].data;
  assign m_tuser  = q[0].kind;
  assign m_tlast  = q[0].last;

  // Escape decoding of the incoming byte.
  always_comb begin
    norm_t      nb;
    logic [4:0] d;
    logic [1:0] dl;
    nb               = normal_step(s_tdata);
    d                = digit_of(s_tdata, mode == MODE_HEX);
    dl               = digits_left - 2'd1;
    mode_next        = mode;
    digits_left_next = digits_left;
    accum_next       = accum;
    n_res            = 2'd0;
    r0               = nb.res;
    r1               = nb.res;
    case (mode)
      MODE_NORMAL: begin
        mode_next = nb.mode;
        n_res     = {1'b0, nb.emit};
      end
      MODE_ESC: begin
        mode_next = MODE_NORMAL;
        n_res     = 2'd1;
        r0.data   = esc_code(s_tdata);
        r0.kind   = KIND_BYTE;
        if (s_tdata == CH_NUL) begin
          r0.kind = KIND_UNTERM;
        end else if (s_tdata == CH_X) begin
          mode_next        = MODE_HEX;
          digits_left_next = HEX_DIGITS;
          accum_next       = 8'h00;
          n_res            = 2'd0;
        end else if (s_tdata == CH_ZERO) begin
          mode_next        = MODE_OCT;
          digits_left_next = OCT_DIGITS;
          accum_next       = 8'h00;
          n_res            = 2'd0;
        end
      end
      default: begin
        if (!d[4] || digits_left == 2'd0) begin
          // cut short: flush the value, then handle the byte as plain text
          r0.data          = accum;
          r0.kind          = KIND_BYTE;
          r1               = nb.res;
          n_res            = nb.emit ? 2'd2 : 2'd1;
          mode_next        = nb.mode;
          digits_left_next = 2'd0;
          accum_next       = 8'h00;
        end else begin
          if (mode == MODE_HEX) accum_next = {accum[3:0], d[3:0]};
          else                  accum_next = {accum[4:0], d[2:0]};
          digits_left_next = dl;
          if (dl == 2'd0) begin
            r0.data    = accum_next;
            r0.kind    = KIND_BYTE;
            n_res      = 2'd1;
            mode_next  = MODE_NORMAL;
            accum_next = 8'h00;
          end
        end
      end
    endcase
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // Result queue: entry 0 drives the output; pop shifts, push appends.
  always_comb begin
    logic [2:0] base;
    base = count - {2'b00, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) q_next[i] = q[i+1];
      else if (pop)              q_next[i] = q[i];
      else                       q_next[i] = q[i];
      if (accept && n_res != 2'd0 && base == 3'(i))
        q_next[i] = r0;
      if (accept && n_res == 2'd2 && base + 3'd1 == 3'(i))
        q_next[i] = r1;
    end
    count_next = base + (accept ? {1'b0, n_res} : 3'd0);
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      mode        <= MODE_NORMAL;
      digits_left <= 2'd0;
      accum       <= 8'h00;
      count       <= 3'd0;
    end else begin
      count <= count_next;
      if (accept) begin
        mode        <= mode_next;
        digits_left <= digits_left_next;
        accum       <= accum_next;
      end
    end
  end

  // Queue never overflows its four entries.
  a_qbound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(QDEPTH))
    else $error("result queue overflow");

  // End markers carry zero data and always close the run.
  a_endmark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_BYTE |-> m_tdata == 8'h00 && m_tlast)
    else $error("end marker malformed");

  // A plain quote in normal mode leaves the decoder in normal mode.
  a_quote: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_NORMAL && s_tdata == CH_QUOTE |=> mode == MODE_NORMAL)
    else $error("quote did not end literal");

  // Entering a numeric escape always starts from a cleared value.
  a_numstart: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_ESC && (s_tdata == CH_X || s_tdata == CH_ZERO)
    |=> accum == 8'h00 && digits_left != 2'd0)
    else $error("numeric escape not initialized");

endmodule
